FILE: src/assert_macros.svh
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define HIJK_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define HIJK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HIJK_ASSERT(lbl, clk, rstn, prop, msg)
`define HIJK_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/hijk_pkg.sv
// Shared types, constants and helpers of the hex IJK coordinate ALU
package hijk_pkg;

    localparam int CW        = 32;  // coordinate arithmetic width
    localparam int FIELD_W   = 32;
    localparam int OP_W      = 5;
    localparam int S_TDATA_W = 7 * FIELD_W;
    localparam int M_TDATA_W = ((4 * FIELD_W + 1 + 7) / 8) * 8;

    // floor(2^CW / 7); estimate of n/7 is exact or one low
    localparam logic [CW-1:0] DIV7_M = {CW{1'b1}} / 7;

    typedef logic signed [CW-1:0]      coord_t;
    typedef logic        [CW-1:0]      ucoord_t;
    typedef logic signed [FIELD_W-1:0] field_t;

    typedef enum logic [OP_W-1:0] {
        OP_NORM     = OP_W'(0),
        OP_ADD      = OP_W'(1),
        OP_SUB      = OP_W'(2),
        OP_SCALE    = OP_W'(3),
        OP_ROT_CCW  = OP_W'(4),
        OP_ROT_CW   = OP_W'(5),
        OP_DOWN7    = OP_W'(6),
        OP_DOWN7R   = OP_W'(7),
        OP_DOWN3    = OP_W'(8),
        OP_DOWN3R   = OP_W'(9),
        OP_UP7      = OP_W'(10),
        OP_UP7R     = OP_W'(11),
        OP_DIST     = OP_W'(12),
        OP_TOIJ     = OP_W'(13),
        OP_TOCUBE   = OP_W'(14),
        OP_FROMCUBE = OP_W'(15),
        OP_MATCH    = OP_W'(16)
    } op_t;

    typedef struct packed {
        coord_t i;
        coord_t j;
        coord_t k;
    } triple_t;

    typedef struct packed {
        op_t     op;
        logic    eq;
        logic    nrm;   // triple still to be normalized
        triple_t t;
    } item_t;

    function automatic coord_t x2(coord_t v);
        return v <<< 1;
    endfunction

    function automatic coord_t x3(coord_t v);
        return v + (v <<< 1);
    endfunction

    function automatic ucoord_t mag(coord_t v);
        coord_t n;
        n = -v;
        return v[CW-1] ? ucoord_t'(n) : ucoord_t'(v);
    endfunction

endpackage

FILE: src/hijk_front.sv
// Front stage: operand decode, add/sub/scale, linear maps and conversions
module hijk_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hijk_pkg::OP_W-1:0]    in_op,
    input  hijk_pkg::triple_t            in_a,
    input  hijk_pkg::triple_t            in_b,
    input  hijk_pkg::coord_t             in_f,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hijk_pkg::item_t              out_item
);
    import hijk_pkg::*;

    logic   valid_reg;
    item_t  item_reg;
    item_t  item_next;
    logic   en;
    coord_t ai, aj, ak, bi, bj, bk;
    coord_t prod_i, prod_j, prod_k;

    assign ai = in_a.i;
    assign aj = in_a.j;
    assign ak = in_a.k;
    assign bi = in_b.i;
    assign bj = in_b.j;
    assign bk = in_b.k;

    assign prod_i = ai * in_f;
    assign prod_j = aj * in_f;
    assign prod_k = ak * in_f;

    always_comb begin
        item_next.op  = op_t'(in_op);
        item_next.eq  = (in_a == in_b);
        item_next.nrm = 1'b0;
        item_next.t   = '0;
        case (item_next.op)
            OP_NORM: begin
                item_next.t   = in_a;
                item_next.nrm = 1'b1;
            end
            OP_ADD: item_next.t = triple_t'{i: ai + bi, j: aj + bj, k: ak + bk};
            OP_SUB: item_next.t = triple_t'{i: ai - bi, j: aj - bj, k: ak - bk};
            OP_SCALE: item_next.t = triple_t'{i: prod_i, j: prod_j, k: prod_k};
            OP_ROT_CCW: begin
                item_next.t   = triple_t'{i: ai + ak, j: ai + aj, k: aj + ak};
                item_next.nrm = 1'b1;
            end
            OP_ROT_CW: begin
                item_next.t   = triple_t'{i: ai + aj, j: aj + ak, k: ai + ak};
                item_next.nrm = 1'b1;
            end
            OP_DOWN7: begin
                item_next.t   = triple_t'{i: x3(ai) + aj, j: x3(aj) + ak, k: ai + x3(ak)};
                item_next.nrm = 1'b1;
            end
            OP_DOWN7R: begin
                item_next.t   = triple_t'{i: x3(ai) + ak, j: ai + x3(aj), k: aj + x3(ak)};
                item_next.nrm = 1'b1;
            end
            OP_DOWN3: begin
                item_next.t   = triple_t'{i: x2(ai) + aj, j: x2(aj) + ak, k: ai + x2(ak)};
                item_next.nrm = 1'b1;
            end
            OP_DOWN3R: begin
                item_next.t   = triple_t'{i: x2(ai) + ak, j: ai + x2(aj), k: aj + x2(ak)};
                item_next.nrm = 1'b1;
            end
            OP_UP7, OP_UP7R: begin
                // IJ form; the divide stages finish the parent
                item_next.t   = triple_t'{i: ai - ak, j: aj - ak, k: '0};
                item_next.nrm = 1'b1;
            end
            OP_DIST: begin
                item_next.t   = triple_t'{i: ai - bi, j: aj - bj, k: ak - bk};
                item_next.nrm = 1'b1;
            end
            OP_TOIJ: item_next.t = triple_t'{i: ai - ak, j: aj - ak, k: '0};
            OP_TOCUBE: item_next.t = triple_t'{i: ak - ai, j: aj - ak, k: ai - aj};
            OP_FROMCUBE: begin
                item_next.t   = triple_t'{i: -ai, j: aj, k: '0};
                item_next.nrm = 1'b1;
            end
            default: item_next.t = '0;
        endcase
    end

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

FILE: src/hijk_div7.sv
// Parent stages: rounded division of the IJ combinations by 7
module hijk_div7 (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hijk_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output hijk_pkg::item_t   out_item
);
    import hijk_pkg::*;

    localparam int NST = 5;

    typedef struct packed {
        logic    sp;
        logic    sq;
        ucoord_t np;
        ucoord_t nq;
    } dnum_t;

    typedef struct packed {
        logic    sp;
        logic    sq;
        logic    ip;
        logic    iq;
        ucoord_t ep;
        ucoord_t eq;
    } dest_t;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;
    item_t          item_reg  [NST];
    item_t          item_next [NST];

    dnum_t   num1_reg, num1_next;
    dnum_t   num2_reg;
    ucoord_t estp2_reg, estq2_reg;
    ucoord_t estp_next, estq_next;
    dest_t   est3_reg, est3_next;

    logic [2*CW-1:0] prod_p, prod_q;
    ucoord_t         rp, rq;
    ucoord_t         qp, qq;
    coord_t          x, y, p, q;

    always_comb begin
        en[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    assign valid_next = {valid_reg[NST-2:0], in_valid};
    assign in_ready   = en[0];

    // stage 0: the two numerators
    always_comb begin
        x = in_item.t.i;
        y = in_item.t.j;
        if (in_item.op == OP_UP7) begin
            p = x3(x) - y;
            q = x + x2(y);
        end else begin
            p = x2(x) + y;
            q = x3(y) - x;
        end
        item_next[0] = in_item;
        if (in_item.op == OP_UP7 || in_item.op == OP_UP7R) begin
            item_next[0].t.i = p;
            item_next[0].t.j = q;
        end
    end

    // stage 1: magnitude plus half the divisor, sign kept aside
    always_comb begin
        item_next[1] = item_reg[0];
        num1_next.sp = item_reg[0].t.i[CW-1];
        num1_next.sq = item_reg[0].t.j[CW-1];
        num1_next.np = mag(item_reg[0].t.i) + ucoord_t'(3);
        num1_next.nq = mag(item_reg[0].t.j) + ucoord_t'(3);
    end

    // stage 2: reciprocal multiply
    always_comb begin
        item_next[2] = item_reg[1];
        prod_p    = (2*CW)'(num1_reg.np) * (2*CW)'(DIV7_M);
        prod_q    = (2*CW)'(num1_reg.nq) * (2*CW)'(DIV7_M);
        estp_next = prod_p[2*CW-1:CW];
        estq_next = prod_q[2*CW-1:CW];
    end

    // stage 3: remainder check, estimate may be one short
    always_comb begin
        item_next[3] = item_reg[2];
        rp = num2_reg.np - ((estp2_reg << 3) - estp2_reg);
        rq = num2_reg.nq - ((estq2_reg << 3) - estq2_reg);
        est3_next.sp = num2_reg.sp;
        est3_next.sq = num2_reg.sq;
        est3_next.ip = (rp >= ucoord_t'(7));
        est3_next.iq = (rq >= ucoord_t'(7));
        est3_next.ep = estp2_reg;
        est3_next.eq = estq2_reg;
    end

    // stage 4: final quotient with sign restored
    always_comb begin
        qp = est3_reg.ep + ucoord_t'(est3_reg.ip);
        qq = est3_reg.eq + ucoord_t'(est3_reg.iq);
        item_next[4] = item_reg[3];
        if (item_reg[3].op == OP_UP7 || item_reg[3].op == OP_UP7R) begin
            item_next[4].t.i = est3_reg.sp ? coord_t'(-qp) : coord_t'(qp);
            item_next[4].t.j = est3_reg.sq ? coord_t'(-qq) : coord_t'(qq);
            item_next[4].t.k = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (en[s]) begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NST; s++) begin
            if (en[s] && valid_next[s]) begin
                item_reg[s] <= item_next[s];
            end
        end
        if (en[1] && valid_next[1]) begin
            num1_reg <= num1_next;
        end
        if (en[2] && valid_next[2]) begin
            num2_reg  <= num1_reg;
            estp2_reg <= estp_next;
            estq2_reg <= estq_next;
        end
        if (en[3] && valid_next[3]) begin
            est3_reg <= est3_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_item  = item_reg[NST-1];

endmodule

FILE: src/hijk_norm.sv
// Normalize stages: clear negatives one component a stage, then remove the minimum
module hijk_norm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  hijk_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output hijk_pkg::item_t   out_item
);
    import hijk_pkg::*;

    localparam int NST = 5;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] valid_next;
    logic [NST-1:0] en;
    item_t          item_reg  [NST];
    item_t          item_next [NST];
    coord_t         min_reg, min_next;
    coord_t         ci, cj, ck;

    always_comb begin
        en[NST-1] = !valid_reg[NST-1] || out_ready;
        for (int s = NST - 2; s >= 0; s--) begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    assign valid_next = {valid_reg[NST-2:0], in_valid};
    assign in_ready   = en[0];

    always_comb begin
        // i negative
        item_next[0] = in_item;
        if (in_item.nrm && in_item.t.i[CW-1]) begin
            item_next[0].t.j = in_item.t.j - in_item.t.i;
            item_next[0].t.k = in_item.t.k - in_item.t.i;
            item_next[0].t.i = '0;
        end
        // j negative
        item_next[1] = item_reg[0];
        if (item_reg[0].nrm && item_reg[0].t.j[CW-1]) begin
            item_next[1].t.i = item_reg[0].t.i - item_reg[0].t.j;
            item_next[1].t.k = item_reg[0].t.k - item_reg[0].t.j;
            item_next[1].t.j = '0;
        end
        // k negative
        item_next[2] = item_reg[1];
        if (item_reg[1].nrm && item_reg[1].t.k[CW-1]) begin
            item_next[2].t.i = item_reg[1].t.i - item_reg[1].t.k;
            item_next[2].t.j = item_reg[1].t.j - item_reg[1].t.k;
            item_next[2].t.k = '0;
        end
        // smallest component
        item_next[3] = item_reg[2];
        ci = item_reg[2].t.i;
        cj = item_reg[2].t.j;
        ck = item_reg[2].t.k;
        min_next = ci;
        if (cj < min_next) begin
            min_next = cj;
        end
        if (ck < min_next) begin
            min_next = ck;
        end
        // subtract it when positive
        item_next[4] = item_reg[3];
        if (item_reg[3].nrm && min_reg > coord_t'(0)) begin
            item_next[4].t.i = item_reg[3].t.i - min_reg;
            item_next[4].t.j = item_reg[3].t.j - min_reg;
            item_next[4].t.k = item_reg[3].t.k - min_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int s = 0; s < NST; s++) begin
                if (en[s]) begin
                    valid_reg[s] <= valid_next[s];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < NST; s++) begin
            if (en[s] && valid_next[s]) begin
                item_reg[s] <= item_next[s];
            end
        end
        if (en[3] && valid_next[3]) begin
            min_reg <= min_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_item  = item_reg[NST-1];

endmodule

FILE: src/hex_ijk_coordinate_alu_top.sv
// Top level of the hex IJK coordinate ALU: stream ports, output stage, checks
//
// Usage:
//   One request on the s_ channel carries an operation code (s_tuser) and two
//   coordinate triples plus a scale factor (s_tdata). Each request produces
//   exactly one result on the m_ channel: a triple, a grid distance and an
//   equality flag, in request order.
//   An accepted request passes one front stage, five parent-divide stages,
//   five normalize stages and the output register on its way to m_tdata.
//   One request per cycle with m_tready high; every stage is a register with
//   its own valid bit, so bubbles close up and nothing is lost on a stall.
//   s_tready follows the ready chain back from the output register: with
//   m_tready high the block always takes a new request, and a stalled
//   receiver holds m_tdata steady until the pipeline fills, then drops
//   s_tready. Reset (aresetn low at a clock edge) empties every stage; the
//   block keeps no state between requests.
//
`include "assert_macros.svh"
module hex_ijk_coordinate_alu_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // coord_i, coord_j, coord_k, other_i, other_j, other_k, scale_factor
    input  logic [hijk_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic [hijk_pkg::OP_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_i, result_j, result_k, hex_distance, triples_equal, zero pad
    output logic [hijk_pkg::M_TDATA_W-1:0]    m_tdata
);
    import hijk_pkg::*;

    triple_t in_a, in_b;
    coord_t  in_f;

    logic  fr_valid, fr_ready;
    item_t fr_item;
    logic  dv_valid, dv_ready;
    item_t dv_item;
    logic  nm_valid, nm_ready;
    item_t nm_item;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    op_t                  out_op_reg;
    logic                 en_out;

    ucoord_t              mi, mj, mk, mx;
    coord_t               ri, rj, rk;
    logic [FIELD_W-1:0]   hd;

    function automatic coord_t field_in(logic [FIELD_W-1:0] v);
        field_t sv;
        sv = field_t'(v);
        return coord_t'(sv);
    endfunction

    assign in_a.i = field_in(s_tdata[0*FIELD_W +: FIELD_W]);
    assign in_a.j = field_in(s_tdata[1*FIELD_W +: FIELD_W]);
    assign in_a.k = field_in(s_tdata[2*FIELD_W +: FIELD_W]);
    assign in_b.i = field_in(s_tdata[3*FIELD_W +: FIELD_W]);
    assign in_b.j = field_in(s_tdata[4*FIELD_W +: FIELD_W]);
    assign in_b.k = field_in(s_tdata[5*FIELD_W +: FIELD_W]);
    assign in_f   = field_in(s_tdata[6*FIELD_W +: FIELD_W]);

    hijk_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_a      (in_a),
        .in_b      (in_b),
        .in_f      (in_f),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    hijk_div7 u_div7 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_item  (dv_item)
    );

    hijk_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_item   (dv_item),
        .out_valid (nm_valid),
        .out_ready (nm_ready),
        .out_item  (nm_item)
    );

    // output stage: distance from the normalized difference, field packing
    always_comb begin
        mi = mag(nm_item.t.i);
        mj = mag(nm_item.t.j);
        mk = mag(nm_item.t.k);
        mx = mi;
        if (mj > mx) begin
            mx = mj;
        end
        if (mk > mx) begin
            mx = mk;
        end
        ri = nm_item.t.i;
        rj = nm_item.t.j;
        rk = nm_item.t.k;
        hd = '0;
        if (nm_item.op == OP_DIST) begin
            ri = '0;
            rj = '0;
            rk = '0;
            hd = FIELD_W'(mx);
        end
        m_tdata_next = {{(M_TDATA_W - 4*FIELD_W - 1){1'b0}}, nm_item.eq, hd,
                        FIELD_W'(rk), FIELD_W'(rj), FIELD_W'(ri)};
    end

    assign en_out   = !m_tvalid_reg || m_tready;
    assign nm_ready = en_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= nm_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && nm_valid) begin
            m_tdata_reg <= m_tdata_next;
            out_op_reg  <= nm_item.op;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `HIJK_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `HIJK_ASSERT(a_ready_chain, aclk, aresetn, m_tready |-> s_tready, "ready lost while sink ready")
    `HIJK_ASSERT(a_dist_only, aclk, aresetn, m_tvalid && out_op_reg != OP_DIST |-> m_tdata[4*FIELD_W-1:3*FIELD_W] == '0, "distance on non-distance request")
    `HIJK_ASSERT(a_zero_triple, aclk, aresetn, m_tvalid && (out_op_reg == OP_DIST || out_op_reg == OP_MATCH) |-> m_tdata[3*FIELD_W-1:0] == '0, "triple not zero")

endmodule

FILE: sim/tb.sv
// Self-checking stream testbench for the hex IJK coordinate ALU top level
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hijk_pkg::*;

    localparam int     RAND_REQS   = 1125;
    localparam int     HOLD_AT     = 420;     // result count that starts the long stall
    localparam int     HOLD_CYCLES = 120;
    localparam int     TAIL_CYCLES = 40;
    localparam int     LIMIT       = 400000;
    localparam coord_t MAXV        = 32'sh7fffffff;
    localparam coord_t MINV        = 32'sh80000000;

    typedef struct {
        coord_t i;
        coord_t j;
        coord_t k;
    } cell_t;

    typedef struct {
        logic [OP_W-1:0] op;
        coord_t          ci, cj, ck;
        coord_t          oi, oj, ok;
        coord_t          sf;
        int              gap;
        bit              drain;   // hold until every result is back
    } alu_req_t;

    typedef struct {
        coord_t      ri, rj, rk;
        logic [31:0] hdist;
        logic        eq;
    } alu_res_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [OP_W-1:0]      s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    alu_req_t req_q[$];
    alu_res_t pending_results[$];
    alu_req_t cur;
    bit       have_cur  = 0;
    int       wait_left = 0;
    int       sent_cnt  = 0;
    int       got_cnt   = 0;
    int       hold_left = 0;
    bit       rx_fast   = 0;
    int       n_sent    = 0;
    int       n_got     = 0;
    bit       all_sent  = 0;
    int       errors    = 0;
    int       cycles    = 0;

    hex_ijk_coordinate_alu_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // clear negatives, then pull the smallest positive component down to zero
    function automatic cell_t canon(cell_t c);
        coord_t m;
        if (c.i < 0) begin
            c.j = c.j - c.i;
            c.k = c.k - c.i;
            c.i = '0;
        end
        if (c.j < 0) begin
            c.i = c.i - c.j;
            c.k = c.k - c.j;
            c.j = '0;
        end
        if (c.k < 0) begin
            c.i = c.i - c.k;
            c.j = c.j - c.k;
            c.k = '0;
        end
        m = c.i;
        if (c.j < m) m = c.j;
        if (c.k < m) m = c.k;
        if (m > 0) begin
            c.i = c.i - m;
            c.j = c.j - m;
            c.k = c.k - m;
        end
        return c;
    endfunction

    function automatic logic [31:0] mag32(coord_t v);
        return v < 0 ? 32'(-v) : 32'(v);
    endfunction

    // nearest, half away from zero
    function automatic coord_t round_div7(coord_t n);
        logic [63:0] q;
        q = ({32'd0, mag32(n)} + 64'd3) / 64'd7;
        return n < 0 ? -coord_t'(q[31:0]) : coord_t'(q[31:0]);
    endfunction

    // all rotation and child maps are circulant: rows (a b c), (c a b), (b c a)
    function automatic cell_t circ_map(cell_t v, int a, int b, int c);
        cell_t r;
        r.i = v.i * a + v.j * b + v.k * c;
        r.j = v.i * c + v.j * a + v.k * b;
        r.k = v.i * b + v.j * c + v.k * a;
        return canon(r);
    endfunction

    function automatic alu_res_t hex_op_result(alu_req_t q);
        cell_t       a, b, r, d;
        coord_t      x, y;
        logic [31:0] dm;
        alu_res_t    res;
        a = cell_t'{q.ci, q.cj, q.ck};
        b = cell_t'{q.oi, q.oj, q.ok};
        r = cell_t'{coord_t'(0), coord_t'(0), coord_t'(0)};
        res.hdist = '0;
        res.eq = (a.i == b.i) && (a.j == b.j) && (a.k == b.k);
        x = a.i - a.k;
        y = a.j - a.k;
        case (q.op)
            OP_NORM:     r = canon(a);
            OP_ADD:      r = cell_t'{a.i + b.i, a.j + b.j, a.k + b.k};
            OP_SUB:      r = cell_t'{a.i - b.i, a.j - b.j, a.k - b.k};
            OP_SCALE:    r = cell_t'{a.i * q.sf, a.j * q.sf, a.k * q.sf};
            OP_ROT_CCW:  r = circ_map(a, 1, 0, 1);
            OP_ROT_CW:   r = circ_map(a, 1, 1, 0);
            OP_DOWN7:    r = circ_map(a, 3, 1, 0);
            OP_DOWN7R:   r = circ_map(a, 3, 0, 1);
            OP_DOWN3:    r = circ_map(a, 2, 1, 0);
            OP_DOWN3R:   r = circ_map(a, 2, 0, 1);
            OP_UP7:      r = canon(cell_t'{round_div7(3 * x - y), round_div7(x + 2 * y),
                                           coord_t'(0)});
            OP_UP7R:     r = canon(cell_t'{round_div7(2 * x + y), round_div7(3 * y - x),
                                           coord_t'(0)});
            OP_DIST: begin
                d = canon(cell_t'{a.i - b.i, a.j - b.j, a.k - b.k});
                dm = mag32(d.i);
                if (mag32(d.j) > dm) dm = mag32(d.j);
                if (mag32(d.k) > dm) dm = mag32(d.k);
                res.hdist = dm;
            end
            OP_TOIJ:     r = cell_t'{x, y, coord_t'(0)};
            OP_TOCUBE: begin
                r.i = a.k - a.i;
                r.j = a.j - a.k;
                r.k = -r.i - r.j;
            end
            OP_FROMCUBE: r = canon(cell_t'{-a.i, a.j, coord_t'(0)});
            default:     r = cell_t'{coord_t'(0), coord_t'(0), coord_t'(0)};
        endcase
        res.ri = r.i;
        res.rj = r.j;
        res.rk = r.k;
        return res;
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            2, 3:    return coord_t'($urandom_range(0, 40)) - 20;
            4:       return coord_t'($urandom_range(0, 2000)) - 1000;
            5: begin
                case ($urandom_range(0, 4))
                    0:       return MINV;
                    1:       return MAXV;
                    2:       return -1;
                    3:       return 0;
                    default: return 1;
                endcase
            end
            6:       return coord_t'($urandom_range(0, 15));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic int draw_gap(bit fast);
        return fast ? 0 : int'($urandom_range(0, 17));
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input coord_t ci, input coord_t cj,
                           input coord_t ck, input coord_t oi, input coord_t oj,
                           input coord_t ok, input coord_t sf, input int gap, input bit drain);
        alu_req_t q;
        q.op = op;
        q.ci = ci; q.cj = cj; q.ck = ck;
        q.oi = oi; q.oj = oj; q.ok = ok;
        q.sf = sf;
        q.gap = gap;
        q.drain = drain;
        req_q.push_back(q);
    endtask

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", got_cnt, what, got, want);
        errors++;
    endtask

    // request driver
    always @(posedge aclk) begin : drive_proc
        bit offer;
        offer = 0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(hex_op_result(cur));
                sent_cnt++;
                have_cur = 0;
            end
            if (!have_cur && req_q.size() > 0) begin
                cur = req_q.pop_front();
                have_cur = 1;
                wait_left = cur.gap;
                s_tdata <= {cur.sf, cur.ok, cur.oj, cur.oi, cur.ck, cur.cj, cur.ci};
                s_tuser <= cur.op;
            end
            if (have_cur) begin
                if (wait_left > 0) wait_left--;
                else if (!cur.drain || n_got == sent_cnt) offer = 1;
            end
            s_tvalid <= offer;
            n_sent <= sent_cnt;
            all_sent <= !have_cur && req_q.size() == 0;
        end
    end

    // result receiver and checker
    always @(posedge aclk) begin : sink_proc
        alu_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_cnt++;
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected", m_tdata[31:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_tdata[31:0] !== want.ri)
                        flag_mismatch("result_i", m_tdata[31:0], want.ri);
                    if (m_tdata[63:32] !== want.rj)
                        flag_mismatch("result_j", m_tdata[63:32], want.rj);
                    if (m_tdata[95:64] !== want.rk)
                        flag_mismatch("result_k", m_tdata[95:64], want.rk);
                    if (m_tdata[127:96] !== want.hdist)
                        flag_mismatch("hex_distance", m_tdata[127:96], want.hdist);
                    if (m_tdata[128] !== want.eq)
                        flag_mismatch("triples_equal", 32'(m_tdata[128]), 32'(want.eq));
                end
                if (got_cnt % 64 == 0) rx_fast = ($urandom_range(0, 3) == 0);
                if (got_cnt == HOLD_AT) hold_left = HOLD_CYCLES;
                else hold_left = draw_gap(rx_fast);
            end else if (hold_left > 0) begin
                hold_left--;
            end
            m_tready <= (hold_left == 0);
            n_got <= got_cnt;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stim
        bit     tx_fast;
        bit     same;
        bit     drain;
        int     gap;
        coord_t ci, cj, ck, oi, oj, ok;
        logic [OP_W-1:0] op;
        tx_fast = 0;

        // directed: every operation, extremes, wraparound, equality, unknown codes
        add_req(OP_NORM,     -5, 3, -2,         0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_NORM,     7, 5, 9,           0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_ADD,      MAXV, 1, -1,       1, MAXV, MINV,    0, draw_gap(0), 0);
        add_req(OP_SUB,      MINV, 0, 5,        1, MINV, -7,      0, draw_gap(1), 0);
        add_req(OP_SCALE,    MINV, 3, -2,       0, 0, 0,         -1, draw_gap(0), 0);
        add_req(OP_ROT_CCW,  1, 0, 0,           0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_ROT_CW,   0, 2, 5,           0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_DOWN7,    1, 2, 3,           0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_DOWN7R,   MAXV, 0, 1,        0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_DOWN3,    4, 0, 9,           0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_DOWN3R,   MINV, MINV, 2,     0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_UP7,      4, 0, 0,           0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_UP7R,     0, 3, 1,           0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_UP7,      MINV, MAXV, MINV,  0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_UP7R,     -4, -1, 0,         0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_DIST,     3, 1, 0,           3, 1, 0,          0, draw_gap(1), 0);
        add_req(OP_DIST,     MINV, 0, 0,        0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_DIST,     10, 2, 0,          0, 5, 1,          0, draw_gap(1), 0);
        add_req(OP_TOIJ,     5, MINV, MAXV,     0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_TOCUBE,   2, 7, -3,          0, 0, 0,          0, draw_gap(1), 0);
        add_req(OP_FROMCUBE, 3, -4, 99,         0, 0, 0,          0, draw_gap(0), 0);
        add_req(OP_MATCH,    -1, -1, -1,        -1, -1, -1,      -1, draw_gap(1), 0);
        add_req(OP_MATCH,    MAXV, 0, MINV,     MAXV, 1, MINV,    0, draw_gap(0), 0);
        add_req(OP_W'(17),   6, 6, 6,           6, 6, 6,          6, draw_gap(1), 0);
        add_req(OP_W'(31),   MAXV, -1, MINV,    -1, MAXV, 0,   MINV, draw_gap(0), 0);

        for (int n = 0; n < RAND_REQS; n++) begin
            if (n % 50 == 0) tx_fast = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0) op = OP_W'($urandom_range(17, 31));
            else op = OP_W'($urandom_range(0, 16));
            ci = rand_coord();
            cj = rand_coord();
            ck = rand_coord();
            same = ($urandom_range(0, 7) == 0);
            oi = same ? ci : rand_coord();
            oj = same ? cj : rand_coord();
            ok = same ? ck : rand_coord();
            // back-to-back requests while the receiver stalls long
            gap = (n >= 360 && n < 560) ? 0 : draw_gap(tx_fast);
            drain = (n == 700) ||
                    (!(n >= 360 && n < 560) && ($urandom_range(0, 149) == 0));
            add_req(op, ci, cj, ck, oi, oj, ok, rand_coord(), gap, drain);
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(all_sent && n_got == n_sent)) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0)
            flag_mismatch("leftover", pending_results.size(), '0);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
